// File: design/bdeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_pkg - shared types for the bounded double-ended queue
// Operation, status and command codes, the record layout and the command
// word that travels from the classifier to the storage side.
// ----------------------------------------------------------------------------
package bdeq_pkg;

	localparam int FIELD_W    = 16;  // one record field
	localparam int POS_W      = 10;  // read position from the front
	localparam int OCC_W      = 11;  // reported occupancy
	localparam int KIND_W     = 3;
	localparam int TDATA_W    = 64;  // stream data width, whole bytes
	localparam int CMDQ_DEPTH = 4;   // command queue between front and back

	// requested operation, carried on s_tuser
	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_BACK  = 3'd0,
		KIND_PUSH_FRONT = 3'd1,
		KIND_POP_BACK   = 3'd2,
		KIND_POP_FRONT  = 3'd3,
		KIND_READ       = 3'd4
	} kind_t;

	// result status, carried on m_tuser
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// what the storage side has to do with the record store
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef struct packed {
		logic [FIELD_W-1:0] output_rate;
		logic [FIELD_W-1:0] hours;
		logic [FIELD_W-1:0] workers;
	} rec_t;

	// classified word handed to the storage side (slot address travels beside it)
	typedef struct packed {
		op_t              op;
		status_t          status;
		rec_t             rec;
		logic [OCC_W-1:0] occupancy;
	} cmd_t;

endpackage

// File: design/bdeq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_front - operation classifier and ring pointer keeper
// Holds the front slot and the held count, checks each word against them,
// updates them on accept and emits a command with the resolved slot.
// ----------------------------------------------------------------------------
module bdeq_front import bdeq_pkg::*; #(
	parameter int DEPTH = 1024,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [KIND_W-1:0] kind,
	input  rec_t              rec_in,
	input  logic [POS_W-1:0]  position,
	input  logic              accept,
	output cmd_t              cmd,
	output logic [ADDR_W-1:0] addr
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [ADDR_W-1:0] front_q, front_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              full, empty;
	logic [ADDR_W-1:0] offset, front_inc, front_dec, slot;
	logic [ADDR_W:0]   sum;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// front + offset modulo DEPTH; the sum stays below twice DEPTH
	assign offset = (kind_t'(kind) == KIND_PUSH_BACK) ? ADDR_W'(count_q) : ADDR_W'(position);
	assign sum    = {1'b0, front_q} + {1'b0, offset};
	assign slot   = (sum >= (ADDR_W+1)'(DEPTH)) ? ADDR_W'(sum - (ADDR_W+1)'(DEPTH))
	                                            : ADDR_W'(sum);

	assign front_inc = (front_q == ADDR_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? ADDR_W'(DEPTH - 1) : front_q - 1'b1;

	// classify and compute the next pointer state
	always_comb begin
		front_d    = front_q;
		count_d    = count_q;
		cmd.op     = OP_NONE;
		cmd.status = ST_OK;
		cmd.rec    = rec_in;
		addr       = slot;
		case (kind_t'(kind))
			KIND_PUSH_BACK: begin
				if (full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.op  = OP_WRITE;
					count_d = count_q + 1'b1;
				end
			end
			KIND_PUSH_FRONT: begin
				addr = front_dec;
				if (full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.op  = OP_WRITE;
					front_d = front_dec;
					count_d = count_q + 1'b1;
				end
			end
			KIND_POP_BACK: begin
				if (empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					front_d = front_inc;
					count_d = count_q - 1'b1;
				end
			end
			KIND_READ: begin
				if (CMP_W'(position) >= CMP_W'(count_q)) begin
					cmd.status = ST_RANGE;
				end else begin
					cmd.op = OP_READ;
				end
			end
			default: begin
				// unused codes leave the queue alone
			end
		endcase
		cmd.occupancy = OCC_W'(count_d);
	end

	// pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

endmodule

// File: design/bdeq_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_cmdq - small command queue
// Decouples the classifier from the storage side; each side stalls alone.
// ----------------------------------------------------------------------------
module bdeq_cmdq #(
	parameter int WIDTH   = 8,
	parameter int DEPTH_Q = 4,
	localparam int PTR_W  = $clog2(DEPTH_Q)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] entries_q [DEPTH_Q];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;
	logic             push, pop;

	assign in_ready  = (cnt_q != (PTR_W+1)'(DEPTH_Q));
	assign out_valid = (cnt_q != '0);
	assign out_data  = entries_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= in_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH_Q - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH_Q - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: design/bdeq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_back - record store and result stage
// Carries out writes and reads on the record store in queue order and
// registers one result word for the output stream.
// ----------------------------------------------------------------------------
module bdeq_back import bdeq_pkg::*; #(
	parameter int DEPTH = 1024,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cmd_t              in_cmd,
	input  logic [ADDR_W-1:0] in_addr,
	output logic              out_valid,
	input  logic              out_ready,
	output cmd_t              out_cmd
);

	rec_t mem [DEPTH];
	rec_t rdata_q;

	logic valid_s1;
	cmd_t cmd_s1;
	logic out_valid_q;
	cmd_t out_q;
	logic advance, issue;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign issue    = in_valid && in_ready;

	// record store, at most one access per command; read data held while stalled
	always_ff @(posedge clk) begin
		if (issue && (in_cmd.op == OP_WRITE)) begin
			mem[in_addr] <= in_cmd.rec;
		end
		if (issue && (in_cmd.op == OP_READ)) begin
			rdata_q <= mem[in_addr];
		end
	end

	// access stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_s1 <= in_cmd;
		end
	end

	// result register; record fields only for a successful read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.op        <= cmd_s1.op;
			out_q.status    <= cmd_s1.status;
			out_q.occupancy <= cmd_s1.occupancy;
			out_q.rec       <= (cmd_s1.op == OP_READ) ? rdata_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_cmd   = out_q;

endmodule

// File: design/bounded_double_ended_queue.sv
`timescale 1ns / 1ps
// An accepted word passes the command queue, the access stage and the
// result register before its result shows on m_tdata. Throughput: one word
// per cycle while results are taken; the record store does one access a
// cycle. The input stalls only when the four-entry command queue is full.
// Reset (arst_n low) empties the queue; the record store is not cleared and
// is only read at slots that hold live records.
// ----------------------------------------------------------------------------
// bounded_double_ended_queue - ring-buffer deque of three-field records
// Push or pop at either end, or read at an index from the front; one result
// word per input word with status, record read and occupancy.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue import bdeq_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// [15:0] workers_in, [31:16] hours_in, [47:32] output_rate_in, [57:48] position
	input  logic [TDATA_W-1:0] s_tdata,
	// [2:0] kind
	input  logic [KIND_W-1:0]  s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// [15:0] workers_out, [31:16] hours_out, [47:32] output_rate_out, [58:48] occupancy
	output logic [TDATA_W-1:0] m_tdata,
	// [1:0] status
	output logic [1:0]         m_tuser
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int QW     = $bits(cmd_t) + ADDR_W;
	localparam int PAD_W  = TDATA_W - OCC_W - 3 * FIELD_W;

	rec_t              rec_in;
	cmd_t              f_cmd, q_cmd, b_cmd;
	logic [ADDR_W-1:0] f_addr, q_addr;
	logic [QW-1:0]     q_out;
	logic              accept, q_valid, b_ready;

	assign rec_in.workers     = s_tdata[FIELD_W-1:0];
	assign rec_in.hours       = s_tdata[2*FIELD_W-1:FIELD_W];
	assign rec_in.output_rate = s_tdata[3*FIELD_W-1:2*FIELD_W];
	assign accept             = s_tvalid && s_tready;

	bdeq_front #(.DEPTH(DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.kind     (s_tuser),
		.rec_in   (rec_in),
		.position (s_tdata[3*FIELD_W+POS_W-1:3*FIELD_W]),
		.accept   (accept),
		.cmd      (f_cmd),
		.addr     (f_addr)
	);

	bdeq_cmdq #(.WIDTH(QW), .DEPTH_Q(CMDQ_DEPTH)) u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   ({f_cmd, f_addr}),
		.out_valid (q_valid),
		.out_ready (b_ready),
		.out_data  (q_out)
	);

	assign q_cmd  = q_out[QW-1:ADDR_W];
	assign q_addr = q_out[ADDR_W-1:0];

	bdeq_back #(.DEPTH(DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (b_ready),
		.in_cmd    (q_cmd),
		.in_addr   (q_addr),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_cmd   (b_cmd)
	);

	// result word packing
	assign m_tdata = {{PAD_W{1'b0}}, b_cmd.occupancy, b_cmd.rec.output_rate,
	                  b_cmd.rec.hours, b_cmd.rec.workers};
	assign m_tuser = b_cmd.status;

	// a failed word carries no record (non-read words carry none either; only failed ones are checked here)
	a_rec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[3*FIELD_W-1:0] == '0))
		else $error("record fields set on a word that is not a read");

	// a refused push reports a full queue
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_FULL)) |->
		(m_tdata[3*FIELD_W+OCC_W-1:3*FIELD_W] == OCC_W'(DEPTH)))
		else $error("full status with occupancy below depth");

	// a refused pop reports an empty queue
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_EMPTY)) |->
		(m_tdata[3*FIELD_W+OCC_W-1:3*FIELD_W] == '0))
		else $error("empty status with nonzero occupancy");

endmodule
